/* hw/rtl/lfu_cache_table_defines.svh */
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Shared property forms for the checker of the cache table.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lct assertion failed");

// Next-cycle implication, disabled during reset
`define LCT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lct assertion failed");

`endif

/* hw/rtl/lct_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache table package
// Sizes, command codes and the scan unit result type.
// ----------------------------------------------------------------------------
package lct_pkg;

   localparam int NumEntries = 16;
   localparam int IdxW       = (NumEntries > 1) ? $clog2(NumEntries) : 1;
   localparam int OccW       = $clog2(NumEntries + 1);
   localparam int CapW       = 5;
   localparam int LimW       = (OccW > CapW) ? OccW : CapW;
   localparam int KeyW       = 32;
   localparam int DataW      = 32;
   localparam int CountW     = 32;
   localparam int StampW     = 64;

   localparam logic [CapW-1:0] CapReset = CapW'(16);

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Per-entry verdict of the shared compare unit
   typedef struct packed {
      logic key_match;   // valid entry holding the requested key
      logic take_victim; // valid entry that beats the current victim
   } scan_res_type;

endpackage

/* hw/rtl/lct_scan.sv */
// ----------------------------------------------------------------------------
// LFU cache table scan unit
// One key comparator and one count/stamp comparator, shared over all entries.
// ----------------------------------------------------------------------------
module lct_scan import lct_pkg::*; (
   input  logic              ent_valid,
   input  logic [KeyW-1:0]   ent_key,
   input  logic [CountW-1:0] ent_count,
   input  logic [StampW-1:0] ent_stamp,
   input  logic [KeyW-1:0]   key,
   input  logic              best_have,
   input  logic [CountW-1:0] best_count,
   input  logic [StampW-1:0] best_stamp,
   output scan_res_type      res
);

   logic count_less;
   logic count_equal;
   logic stamp_older;

   // Order by use count, then by age
   assign count_less  = ent_count < best_count;
   assign count_equal = ent_count == best_count;
   assign stamp_older = ent_stamp < best_stamp;

   assign res.key_match   = ent_valid && (ent_key == key);
   assign res.take_victim = ent_valid &&
                            (!best_have || count_less || (count_equal && stamp_older));

endmodule

/* hw/rtl/lfu_cache_table.sv */
// ----------------------------------------------------------------------------
// LFU cache table: 16-entry key/value cache, LFU replacement, LRU tie-break
// Get or update: lookup to hit or last entry, apply, result. New-key put:
// full lookup, apply, one eviction scan per eviction and insert unless the
// capacity is zero, result. The next item is taken in the cycle after the
// result register loads; one comparator scans one entry per cycle.
// Reset clears all valid bits and the stamp counter and sets capacity to 16.
// ----------------------------------------------------------------------------
module lfu_cache_table import lct_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   input  logic signed [KeyW-1:0]  req_key,
   input  logic signed [DataW-1:0] req_write_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic signed [DataW-1:0] rsp_read_value,
   input  logic                    csr_write_enable,
   input  logic [CapW-1:0]         csr_write_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_APPLY  = 3'd2;
   localparam logic [2:0] S_EVICT  = 3'd3;
   localparam logic [2:0] S_INSERT = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   localparam logic [IdxW-1:0]   LastIdx  = IdxW'(NumEntries - 1);
   localparam logic [CountW-1:0] CountMax = '1;

   // Entry store
   logic              valid_ff [NumEntries];
   logic [KeyW-1:0]   ekey_ff  [NumEntries];
   logic [DataW-1:0]  edata_ff [NumEntries];
   logic [CountW-1:0] ecnt_ff  [NumEntries];
   logic [StampW-1:0] estamp_ff[NumEntries];

   // Control state
   logic [2:0]        state_ff, state_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic [CapW-1:0]   cap_ff;
   logic [LimW-1:0]   lim_ff, lim_in;
   logic [LimW-1:0]   occ_ff, occ_in;
   logic [StampW-1:0] stamp_ff, stamp_in;
   logic              found_ff, found_in;
   logic              free_have_ff, free_have_in;
   logic              vic_have_ff, vic_have_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working payload
   logic              cmd_ff, cmd_in;
   logic [KeyW-1:0]   key_ff, key_in;
   logic [DataW-1:0]  wval_ff, wval_in;
   logic [IdxW-1:0]   slot_ff, slot_in;
   logic [DataW-1:0]  rdata_ff, rdata_in;
   logic [CountW-1:0] hcnt_ff, hcnt_in;
   logic [IdxW-1:0]   free_ff, free_in;
   logic [IdxW-1:0]   vic_ff, vic_in;
   logic [CountW-1:0] vic_cnt_ff, vic_cnt_in;
   logic [StampW-1:0] vic_stamp_ff, vic_stamp_in;
   logic              res_hit_ff, res_hit_in;
   logic [DataW-1:0]  res_val_ff, res_val_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [DataW-1:0]  rsp_val_ff, rsp_val_in;

   // Store write controls
   logic              touch_en;
   logic              upd_en;
   logic              ins_en;
   logic              clr_en;
   logic [IdxW-1:0]   clr_idx;

   logic              fin_have;
   logic [IdxW-1:0]   fin_idx;
   scan_res_type      scan;

   lct_scan u_scan (
      .ent_valid  (valid_ff[idx_ff]),
      .ent_key    (ekey_ff[idx_ff]),
      .ent_count  (ecnt_ff[idx_ff]),
      .ent_stamp  (estamp_ff[idx_ff]),
      .key        (key_ff),
      .best_have  (vic_have_ff),
      .best_count (vic_cnt_ff),
      .best_stamp (vic_stamp_ff),
      .res        (scan)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_val_ff;

   // Victim after this entry is weighed
   assign fin_have = scan.take_victim || vic_have_ff;
   assign fin_idx  = scan.take_victim ? idx_ff : vic_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      lim_in       = lim_ff;
      occ_in       = occ_ff;
      stamp_in     = stamp_ff;
      found_in     = found_ff;
      free_have_in = free_have_ff;
      vic_have_in  = vic_have_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      wval_in      = wval_ff;
      slot_in      = slot_ff;
      rdata_in     = rdata_ff;
      hcnt_in      = hcnt_ff;
      free_in      = free_ff;
      vic_in       = vic_ff;
      vic_cnt_in   = vic_cnt_ff;
      vic_stamp_in = vic_stamp_ff;
      res_hit_in   = res_hit_ff;
      res_val_in   = res_val_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      touch_en     = 1'b0;
      upd_en       = 1'b0;
      ins_en       = 1'b0;
      clr_en       = 1'b0;
      clr_idx      = fin_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_command;
               key_in       = req_key;
               wval_in      = req_write_value;
               lim_in       = (cap_ff > CapW'(NumEntries)) ? LimW'(NumEntries)
                                                           : LimW'(cap_ff);
               idx_in       = '0;
               found_in     = 1'b0;
               free_have_in = 1'b0;
               state_in     = S_LOOKUP;
            end
         end

         // Scan for the key; note the lowest free slot on the way
         S_LOOKUP: begin
            if (scan.key_match) begin
               found_in = 1'b1;
               slot_in  = idx_ff;
               rdata_in = edata_ff[idx_ff];
               hcnt_in  = ecnt_ff[idx_ff];
               state_in = S_APPLY;
            end else begin
               if (!valid_ff[idx_ff] && !free_have_ff) begin
                  free_have_in = 1'b1;
                  free_in      = idx_ff;
               end
               if (idx_ff == LastIdx) begin
                  state_in = S_APPLY;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_APPLY: begin
            state_in = S_RESP;
            if (found_ff) begin
               touch_en   = 1'b1;
               stamp_in   = stamp_ff + 1'b1;
               res_hit_in = 1'b1;
               if (cmd_ff == CMD_PUT) begin
                  upd_en     = 1'b1;
                  res_val_in = '0;
               end else begin
                  res_val_in = rdata_ff;
               end
            end else if (cmd_ff == CMD_GET) begin
               res_hit_in = 1'b0;
               res_val_in = '1;
            end else begin
               res_hit_in = 1'b0;
               res_val_in = '0;
               if (lim_ff == '0) begin
                  state_in = S_RESP;
               end else if (occ_ff >= lim_ff) begin
                  idx_in      = '0;
                  vic_have_in = 1'b0;
                  state_in    = S_EVICT;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end

         // Search the minimum count, oldest stamp first on ties
         S_EVICT: begin
            if (scan.take_victim) begin
               vic_have_in  = 1'b1;
               vic_in       = idx_ff;
               vic_cnt_in   = ecnt_ff[idx_ff];
               vic_stamp_in = estamp_ff[idx_ff];
            end
            if (idx_ff == LastIdx) begin
               state_in = S_INSERT;
               if (fin_have) begin
                  clr_en = 1'b1;
                  occ_in = occ_ff - 1'b1;
                  if (!free_have_ff || (fin_idx < free_ff)) begin
                     free_in = fin_idx;
                  end
                  free_have_in = 1'b1;
                  if ((occ_ff - 1'b1) >= lim_ff) begin
                     idx_in      = '0;
                     vic_have_in = 1'b0;
                     state_in    = S_EVICT;
                  end
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_INSERT: begin
            ins_en   = 1'b1;
            occ_in   = occ_ff + 1'b1;
            stamp_in = stamp_ff + 1'b1;
            state_in = S_RESP;
         end

         // Hand the result to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_val_in   = res_val_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CapReset;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         free_have_ff <= 1'b0;
         vic_have_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         free_have_ff <= free_have_in;
         vic_have_ff  <= vic_have_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lim_ff       <= lim_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      wval_ff      <= wval_in;
      slot_ff      <= slot_in;
      rdata_ff     <= rdata_in;
      hcnt_ff      <= hcnt_in;
      free_ff      <= free_in;
      vic_ff       <= vic_in;
      vic_cnt_ff   <= vic_cnt_in;
      vic_stamp_ff <= vic_stamp_in;
      res_hit_ff   <= res_hit_in;
      res_val_ff   <= res_val_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_val_ff   <= rsp_val_in;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumEntries; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (clr_en) begin
            valid_ff[clr_idx] <= 1'b0;
         end
         if (ins_en) begin
            valid_ff[free_ff] <= 1'b1;
         end
      end
   end

   // Entry fields: touch, update and insert
   always_ff @(posedge clock) begin
      if (touch_en) begin
         ecnt_ff[slot_ff]   <= (hcnt_ff == CountMax) ? hcnt_ff : hcnt_ff + 1'b1;
         estamp_ff[slot_ff] <= stamp_ff;
      end
      if (upd_en) begin
         edata_ff[slot_ff] <= wval_ff;
      end
      if (ins_en) begin
         ekey_ff[free_ff]   <= key_ff;
         edata_ff[free_ff]  <= wval_ff;
         ecnt_ff[free_ff]   <= CountW'(1);
         estamp_ff[free_ff] <= stamp_ff;
      end
   end

endmodule

/* hw/rtl/lct_checker.sv */
// ----------------------------------------------------------------------------
// LFU cache table port checker
// Watches the top-level ports for handshake and result sanity.
// ----------------------------------------------------------------------------
`include "lfu_cache_table_defines.svh"

module lct_checker import lct_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_hit,
   input logic signed [DataW-1:0] rsp_read_value
);

   // A stalled result holds
   `LCT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))

   // The block is busy right after it takes an item
   `LCT_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // A miss returns either the get marker or the put zero
   `LCT_ASSERT_IMP(a_miss_value, clock, reset, rsp_valid && !rsp_hit, (rsp_read_value == '0) || (rsp_read_value == '1))

   // Leaving reset: idle, nothing pending
   `LCT_ASSERT_IMP(a_reset_idle, clock, reset, $past(reset), req_ready && !rsp_valid)

endmodule

bind lfu_cache_table lct_checker u_lct_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hit        (rsp_hit),
   .rsp_read_value (rsp_read_value)
);

/* tb/sv/tb_lfu_cache_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache table testbench
// Drives get and put items through the request channel with bursty traffic,
// stalls the result channel on its own pattern plus one long hold, and checks
// every result against a cycle-free model of the LFU table with LRU
// tie-break. Capacity is rewritten between phases, including zero, values
// above the table size and values below the current occupancy.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table;
   import lct_pkg::*;

   localparam int StallLimit = 4000;
   localparam int PoolSize   = 24;
   localparam int PhaseCount = 8;

   typedef struct packed {
      logic                    command;
      logic signed [KeyW-1:0]  key;
      logic signed [DataW-1:0] wdata;
   } cache_op_t;

   typedef struct packed {
      logic                    hit;
      logic signed [DataW-1:0] value;
   } cache_reply_t;

   // Block ports
   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   logic                    req_command      = CMD_GET;
   logic signed [KeyW-1:0]  req_key          = '0;
   logic signed [DataW-1:0] req_write_value  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready        = 1'b0;
   logic                    rsp_hit;
   logic signed [DataW-1:0] rsp_read_value;
   logic                    csr_write_enable = 1'b0;
   logic [CapW-1:0]         csr_write_data   = '0;

   // Stimulus and scoreboard
   cache_op_t    pending_ops [$];
   cache_reply_t expected_replies [$];
   logic signed [KeyW-1:0] key_pool [PoolSize];
   int  ops_queued   = 0;
   int  replies_seen = 0;
   int  fail_count   = 0;
   int  idle_cycles  = 0;
   logic req_taken   = 1'b0;

   // Table model state
   logic              tab_valid [NumEntries] = '{default: 1'b0};
   logic [KeyW-1:0]   tab_key   [NumEntries];
   logic [DataW-1:0]  tab_data  [NumEntries];
   logic [CountW-1:0] tab_count [NumEntries];
   logic [StampW-1:0] tab_stamp [NumEntries];
   logic [StampW-1:0] stamp_ctr      = '0;
   logic [CapW-1:0]   model_capacity = CapReset;

   // Coverage tallies for the summary
   int n_get_hits = 0, n_get_misses = 0, n_updates = 0;
   int n_inserts = 0, n_evictions = 0, n_dropped = 0;
   string cap_trail = "";

   // Traffic shaping
   int burst_left = 1, gap_left = 0;
   int hold_left = 0, ready_tick = 0;
   logic hold_done = 1'b0;

   int phase_caps [PhaseCount] = '{4, 0, 1, 31, 2, 17, 9, 16};
   int phase_lens [PhaseCount] = '{150, 120, 120, 200, 150, 200, 150, 200};

   lfu_cache_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_key          (req_key),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Raise the use count (saturating) and restamp the entry
   function automatic void bump_entry(input int slot);
      if (tab_count[slot] != '1)
         tab_count[slot] = tab_count[slot] + 1'b1;
      tab_stamp[slot] = stamp_ctr;
      stamp_ctr = stamp_ctr + 1'b1;
   endfunction

   // Apply one get or put to the table model and return its result
   function automatic cache_reply_t apply_cache_op(input cache_op_t op);
      cache_reply_t reply;
      int slot, victim, occupied, limit, i;
      slot = -1;
      for (i = 0; i < NumEntries; i++)
         if (slot < 0 && tab_valid[i] && tab_key[i] == op.key)
            slot = i;
      reply.hit   = (slot >= 0);
      reply.value = '0;
      if (op.command == CMD_GET) begin
         if (slot >= 0) begin
            reply.value = tab_data[slot];
            bump_entry(slot);
            n_get_hits++;
         end else begin
            reply.value = -1;
            n_get_misses++;
         end
      end else if (slot >= 0) begin
         tab_data[slot] = op.wdata;
         bump_entry(slot);
         n_updates++;
      end else begin
         limit = (model_capacity > NumEntries) ? NumEntries : int'(model_capacity);
         if (limit == 0) begin
            n_dropped++;
         end else begin
            occupied = 0;
            for (i = 0; i < NumEntries; i++)
               if (tab_valid[i])
                  occupied++;
            // Evict lowest count, oldest stamp, until there is room
            while (occupied >= limit) begin
               victim = -1;
               for (i = 0; i < NumEntries; i++)
                  if (tab_valid[i] && (victim < 0 || tab_count[i] < tab_count[victim] ||
                      (tab_count[i] == tab_count[victim] &&
                       tab_stamp[i] < tab_stamp[victim])))
                     victim = i;
               tab_valid[victim] = 1'b0;
               occupied--;
               n_evictions++;
            end
            // Insert into the lowest free slot
            slot = -1;
            for (i = 0; i < NumEntries; i++)
               if (slot < 0 && !tab_valid[i])
                  slot = i;
            tab_valid[slot] = 1'b1;
            tab_key[slot]   = op.key;
            tab_data[slot]  = op.wdata;
            tab_count[slot] = 1;
            tab_stamp[slot] = stamp_ctr;
            stamp_ctr = stamp_ctr + 1'b1;
            n_inserts++;
         end
      end
      return reply;
   endfunction

   task automatic queue_op(input logic cmd, input logic signed [KeyW-1:0] key,
                           input logic signed [DataW-1:0] wdata);
      pending_ops.push_back(cache_op_t'{cmd, key, wdata});
      ops_queued++;
   endtask

   // Mostly pool keys so gets hit and puts update; the rest fully random
   task automatic queue_random_ops(input int count);
      int k;
      logic signed [KeyW-1:0] key;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) < 8)
            key = key_pool[$urandom_range(0, PoolSize - 1)];
         else
            key = $urandom();
         queue_op(($urandom_range(0, 99) < 55) ? CMD_PUT : CMD_GET, key, $urandom());
      end
   endtask

   // Request driver: bursts of random length separated by random gaps
   always @(negedge clock) begin : drive_requests
      cache_op_t next_op;
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            next_op = pending_ops.pop_front();
            req_command     <= next_op.command;
            req_key         <= next_op.key;
            req_write_value <= next_op.wdata;
            req_valid       <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: rotating stall pattern, plus one long hold mid-run
   always @(negedge clock) begin
      ready_tick = ready_tick + 1;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && replies_seen >= 700) begin
         hold_done = 1'b1;
         hold_left = 600;
         rsp_ready <= 1'b0;
      end else begin
         case ((ready_tick / 64) % 3)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= ($urandom_range(0, 9) < 7);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // Monitor: check results, predict accepted items, track progress
   always @(posedge clock) begin : observe_ports
      cache_reply_t want;
      if (!reset) begin
         if (csr_write_enable)
            model_capacity = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            replies_seen <= replies_seen + 1;
            if (expected_replies.size() == 0) begin
               $error("unexpected result: hit %0d read_value %0d", rsp_hit, rsp_read_value);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit mismatch: expected %0d, actual %0d", want.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_read_value !== want.value) begin
                  $error("read_value mismatch: expected %0d, actual %0d",
                         want.value, rsp_read_value);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_replies.push_back(apply_cache_op(
               cache_op_t'{req_command, req_key, req_write_value}));
         req_taken <= req_valid && req_ready;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: end the run if nothing moves for too long
   initial begin
      wait (idle_cycles >= StallLimit);
      $display("ERROR: no item accepted for %0d cycles", StallLimit);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : run_regression
      int k;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (k = 4; k < PoolSize; k++)
         key_pool[k] = (k < 12) ? KeyW'(k) : KeyW'($urandom());

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: miss on empty table, extreme keys and values, hits,
      // update, fill to sixteen and evict the oldest count-one entry
      queue_op(CMD_GET, 32'h0000_0000, 32'h1234_5678);
      queue_op(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_op(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_op(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      queue_op(CMD_GET, 32'h8000_0000, 32'h0);
      queue_op(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_op(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      queue_op(CMD_GET, 32'h0000_0000, 32'h0);
      queue_op(CMD_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
      for (k = 1; k <= 12; k++)
         queue_op(CMD_PUT, KeyW'(k), DataW'(k * 32'h0101_0101));
      queue_op(CMD_PUT, 32'h0000_00FF, 32'hCAFE_0001);
      queue_op(CMD_GET, 32'h0000_0001, 32'h0);
      queue_random_ops(200);

      // Later phases: rewrite capacity once all results are in
      for (k = 0; k < PhaseCount; k++) begin
         wait (replies_seen == ops_queued);
         repeat (8) @(negedge clock);
         csr_write_data   <= CapW'(phase_caps[k]);
         csr_write_enable <= 1'b1;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         cap_trail = {cap_trail, $sformatf(" %0d", phase_caps[k])};
         queue_random_ops(phase_lens[k]);
      end

      wait (replies_seen == ops_queued);
      repeat (30) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $error("%0d results never arrived", expected_replies.size());
         fail_count++;
      end

      $display("Covered %0d items with capacity 16 then%s.", ops_queued, cap_trail);
      $display("Gets: %0d hit, %0d miss. Puts: %0d update, %0d insert, %0d evict, %0d dropped.",
               n_get_hits, n_get_misses, n_updates, n_inserts, n_evictions, n_dropped);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lct_pkg.sv
hw/rtl/lct_scan.sv
hw/rtl/lfu_cache_table.sv
hw/rtl/lct_checker.sv
tb/sv/tb_lfu_cache_table.sv
